[src/handheld_color_correction_unit_assert.svh]
// assertion macros shared by the color correction pipeline
`ifndef HANDHELD_COLOR_CORRECTION_UNIT_ASSERT_SVH
`define HANDHELD_COLOR_CORRECTION_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk, off during reset
`define HCC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define HCC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/hcc_pkg.sv]
package hcc_pkg;

	localparam int unsigned PIX_W  = 15;
	localparam int unsigned CODE_W = 5;
	localparam int unsigned LIN_W  = 16;
	localparam int unsigned X_W    = 17;
	localparam int unsigned OUT_W  = 8;
	localparam int unsigned COEF_W = 15;
	localparam int unsigned PROD_W = 31;
	localparam int unsigned NCH    = 3;

	// linear value one, Q1.16
	localparam logic [X_W-1:0] X_ONE = 17'd65536;

	typedef logic [191:0] wide_t;
	typedef logic [31:0][LIN_W-1:0] lin_tab_t;
	typedef logic [255:0][X_W-1:0] thr_tab_t;
	typedef logic [NCH*NCH-1:0][COEF_W-1:0] coef_tab_t;

	// mixed linear values of one item, with its valid bit
	typedef struct packed {
		logic                      vld;
		logic [NCH-1:0][X_W-1:0]   x;
	} mix_t;

	// Q1.14 mix coefficients, index is out_channel*3 + in_channel
	// (channel order red, green, blue); red-from-blue is -983
	localparam coef_tab_t MIX_COEF = {
		15'd11960, 15'd1229,  15'd3195,
		15'd3441,  15'd10895, 15'd2048,
		15'h7C29,  15'd3932,  15'd13435
	};

	// exact integer power, only used while elaborating the tables
	function automatic wide_t wide_pow(wide_t base, int unsigned n);
		wide_t acc;
		acc = 192'd1;
		for (int unsigned i = 0; i < n; i++)
			acc = acc * base;
		return acc;
	endfunction

	// floor(65536 * 0.94 * (c/31)^1.2) for each 5-bit code
	function automatic lin_tab_t lin_table();
		lin_tab_t     t;
		wide_t        k_lhs;
		wide_t        k_rhs;
		wide_t        rhs;
		wide_t        lhs;
		logic [15:0]  res;
		logic [15:0]  cand;
		k_rhs = wide_pow(192'd6160384, 5);
		k_lhs = wide_pow(192'd100, 5) * wide_pow(192'd31, 6);
		for (int unsigned c = 0; c < 32; c++) begin
			rhs = k_rhs * wide_pow(192'(c), 6);
			res = '0;
			for (int b = 15; b >= 0; b--) begin
				cand = res | (16'd1 << b);
				lhs = wide_pow(192'(cand), 5) * k_lhs;
				if (lhs <= rhs)
					res = cand;
			end
			t[c] = res;
		end
		return t;
	endfunction

	// smallest x with (k/255)^2.2 <= x/65536, i.e. k^11 * 2^80 <= x^5 * 255^11
	function automatic thr_tab_t thr_table();
		thr_tab_t     t;
		wide_t        p255;
		wide_t        lim;
		logic [16:0]  y;
		logic [16:0]  cand;
		p255 = wide_pow(192'd255, 11);
		t[0] = '0;
		for (int unsigned k = 1; k < 256; k++) begin
			lim = wide_pow(192'(k), 11) << 80;
			y = '0;
			for (int b = 16; b >= 0; b--) begin
				cand = y | (17'd1 << b);
				if (wide_pow(192'(cand), 5) * p255 < lim)
					y = cand;
			end
			t[k] = y + 17'd1;
		end
		return t;
	endfunction

	localparam lin_tab_t LIN_TAB   = lin_table();
	localparam thr_tab_t GAMMA_THR = thr_table();

endpackage

[src/hcc_pix_if.sv]
interface hcc_pix_if import hcc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] color_rgb15;

	modport source (output valid, output color_rgb15, input ready);
	modport sink (input valid, input color_rgb15, output ready);
endinterface

[src/hcc_rgb_if.sv]
interface hcc_rgb_if import hcc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] red_out;
	logic [OUT_W-1:0] green_out;
	logic [OUT_W-1:0] blue_out;

	modport source (output valid, output red_out, output green_out, output blue_out,
		input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		output ready);
endinterface

[src/hcc_linmix.sv]
`include "handheld_color_correction_unit_assert.svh"

module hcc_linmix import hcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	hcc_pix_if.sink   pixel,
	output mix_t      mix,
	input  logic      mix_rdy
);

	logic                          vld_s1, vld_s2, vld_s3;
	logic                          rdy_s1, rdy_s2, rdy_s3;
	logic [NCH-1:0][LIN_W-1:0]     lin_s1;
	logic [NCH*NCH-1:0][PROD_W-1:0] prod_s2;
	logic [NCH-1:0][X_W-1:0]       x_s3;
	logic [NCH-1:0][X_W-1:0]       x_d;

	assign rdy_s3      = !vld_s3 || mix_rdy;
	assign rdy_s2      = !vld_s2 || rdy_s3;
	assign rdy_s1      = !vld_s1 || rdy_s2;
	assign pixel.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1)
				vld_s1 <= pixel.valid;
			if (rdy_s2)
				vld_s2 <= vld_s1;
			if (rdy_s3)
				vld_s3 <= vld_s2;
		end
	end

	// gamma-1.2 lookup per channel
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			for (int c = 0; c < NCH; c++)
				lin_s1[c] <= LIN_TAB[pixel.color_rgb15[CODE_W*c +: CODE_W]];
		end
	end

	// nine products of the color matrix
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			for (int ch = 0; ch < NCH; ch++) begin
				for (int j = 0; j < NCH; j++) begin
					prod_s2[ch*NCH + j] <= PROD_W'($signed({1'b0, lin_s1[j]}))
						* PROD_W'($signed(MIX_COEF[ch*NCH + j]));
				end
			end
		end
	end

	// row sums, round to Q1.16, clamp at zero and at one
	always_comb begin
		logic signed [32:0] sum;
		logic signed [32:0] rnd;
		logic [18:0]        q;
		for (int c = 0; c < NCH; c++) begin
			sum = 33'($signed(prod_s2[c*NCH]))
				+ 33'($signed(prod_s2[c*NCH + 1]))
				+ 33'($signed(prod_s2[c*NCH + 2]));
			rnd = sum + 33'sd8192;
			q   = rnd[32:14];
			if (sum <= 33'sd0)
				x_d[c] = '0;
			else if (q > 19'(X_ONE))
				x_d[c] = X_ONE;
			else
				x_d[c] = q[X_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3)
			x_s3 <= x_d;
	end

	assign mix.vld = vld_s3;
	assign mix.x   = x_s3;

	`HCC_ASSERT_NXT(a_prod_hold, vld_s2 && !rdy_s3, vld_s2 && $stable(prod_s2), "product stage lost an item")
	`HCC_ASSERT_NXT(a_mix_hold, vld_s3 && !mix_rdy, vld_s3 && $stable(x_s3), "mix stage lost an item")

endmodule

[src/hcc_gamma.sv]
`include "handheld_color_correction_unit_assert.svh"

module hcc_gamma import hcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mix_t       mix,
	output logic       mix_rdy,
	hcc_rgb_if.source  rgb
);

	logic                      vld_s4, vld_s5, vld_s6, vld_s7;
	logic                      rdy_s4, rdy_s5, rdy_s6, rdy_s7;
	logic [NCH-1:0][X_W-1:0]   x_s4, x_s5, x_s6, x_s7;
	logic [NCH-1:0][OUT_W-1:0] k_s4, k_s5, k_s6, k_s7;

	// two steps of the binary search over the output thresholds
	function automatic logic [OUT_W-1:0] search2(logic [X_W-1:0] x, logic [OUT_W-1:0] k_in,
		int unsigned hi);
		logic [OUT_W-1:0] k;
		logic [OUT_W-1:0] cand;
		k = k_in;
		for (int unsigned i = 0; i < 2; i++) begin
			cand = k | (8'd1 << (hi - i));
			if (x >= GAMMA_THR[cand])
				k = cand;
		end
		return k;
	endfunction

	// k is the largest code whose threshold x reaches
	function automatic logic k_ok(logic [X_W-1:0] x, logic [OUT_W-1:0] k);
		return (x >= GAMMA_THR[k]) && (k == 8'hFF || x < GAMMA_THR[8'(k + 8'd1)]);
	endfunction

	assign rdy_s7  = !vld_s7 || rgb.ready;
	assign rdy_s6  = !vld_s6 || rdy_s7;
	assign rdy_s5  = !vld_s5 || rdy_s6;
	assign rdy_s4  = !vld_s4 || rdy_s5;
	assign mix_rdy = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (rdy_s4)
				vld_s4 <= mix.vld;
			if (rdy_s5)
				vld_s5 <= vld_s4;
			if (rdy_s6)
				vld_s6 <= vld_s5;
			if (rdy_s7)
				vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			x_s4 <= mix.x;
			for (int c = 0; c < NCH; c++)
				k_s4[c] <= search2(mix.x[c], '0, 7);
		end
		if (rdy_s5) begin
			x_s5 <= x_s4;
			for (int c = 0; c < NCH; c++)
				k_s5[c] <= search2(x_s4[c], k_s4[c], 5);
		end
		if (rdy_s6) begin
			x_s6 <= x_s5;
			for (int c = 0; c < NCH; c++)
				k_s6[c] <= search2(x_s5[c], k_s5[c], 3);
		end
		if (rdy_s7) begin
			x_s7 <= x_s6;
			for (int c = 0; c < NCH; c++)
				k_s7[c] <= search2(x_s6[c], k_s6[c], 1);
		end
	end

	assign rgb.valid     = vld_s7;
	assign rgb.red_out   = k_s7[0];
	assign rgb.green_out = k_s7[1];
	assign rgb.blue_out  = k_s7[2];

	`HCC_ASSERT_IMP(a_code_exact, vld_s7, k_ok(x_s7[0], k_s7[0]) && k_ok(x_s7[1], k_s7[1]) && k_ok(x_s7[2], k_s7[2]), "gamma search gave a wrong code")
	`HCC_ASSERT_NXT(a_search_hold, vld_s5 && !rdy_s6, vld_s5 && $stable(k_s5) && $stable(x_s5), "search stage lost an item")

endmodule

[src/handheld_color_correction_unit.sv]
// Handheld LCD color correction, one RGB555 pixel in, one 8-bit RGB pixel out.
// pixel: valid/ready channel carrying color_rgb15 (red in bits 4:0, green 9:5,
//   blue 14:10); an item moves on a clock edge with valid and ready both high.
// rgb: valid/ready channel carrying red_out, green_out and blue_out.
// Pipeline of seven register stages: gamma-1.2 lookup, matrix products,
//   row sum with rounding, then four stages of a two-step-per-stage binary
//   search over the output gamma thresholds.
// Throughput: one item per clock, sustained, as long as rgb is ready.
// Stalls: when rgb.ready is low the result holds; stages behind it keep
//   filling bubbles, so pixel.ready drops only once all seven stages are full.
// Reset (arst_n low, asynchronous) empties every stage; tables are constant
//   logic, so the block takes items from the first cycle after reset.
module handheld_color_correction_unit import hcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	hcc_pix_if.sink    pixel,
	hcc_rgb_if.source  rgb
);

	// mixed linear values between the matrix half and the gamma half
	mix_t mix;
	logic mix_rdy;

	// stages 1 to 3: per-channel linearize and 3x3 mix
	hcc_linmix u_linmix (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pixel),
		.mix     (mix),
		.mix_rdy (mix_rdy)
	);

	// stages 4 to 7: output gamma and 0..255 quantization
	hcc_gamma u_gamma (
		.clk     (clk),
		.arst_n  (arst_n),
		.mix     (mix),
		.mix_rdy (mix_rdy),
		.rgb     (rgb)
	);

endmodule
